// ----- hw/rtl/fpda_pkg.sv -----
package fpda_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;

  localparam int VALUE_W = 64;
  localparam int CFG_W   = 5;
  localparam int PREC_W  = 4;
  localparam int DATA_W  = 8;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      prec;
    logic      round;
    logic      dabble;
    logic      count;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } fpda_cmd_t;

  typedef struct packed {
    logic neg;
    logic prec_zero;
    logic int_last;
    logic frac_last;
    logic dabble_last;
    logic out_free;
  } fpda_status_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < 10; i++) begin
      if (i < n) begin
        r = r * 64'd10;
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/fpda_datapath.sv -----
module fpda_datapath #(
  parameter int MAX_FRACTION_DIGITS = 10,
  parameter int FRACTION_BITS       = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fpda_pkg::fpda_cmd_t       cmd,
  output fpda_pkg::fpda_status_t    status,
  input  logic signed [63:0]        s_tdata,
  input  logic                      cfg_we,
  input  logic signed [4:0]         cfg_data,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,
  output logic                      m_tlast
);
  import fpda_pkg::*;

  localparam int IW   = VALUE_W - FRACTION_BITS;
  localparam int ND   = (IW * 31) / 100 + 1;
  localparam int IDXW = $clog2(ND);
  localparam int DCW  = $clog2(IW);
  localparam int FB   = FRACTION_BITS;

  logic signed [CFG_W-1:0] cfg;
  logic                    neg;
  logic [VALUE_W-1:0]      mag;
  logic [PREC_W-1:0]       prec;
  logic [IW-1:0]           bin;
  logic [FB-1:0]           frac;
  logic [ND*4-1:0]         bcd;
  logic [DCW-1:0]          dcnt;
  logic [IDXW-1:0]         idx;
  logic [PREC_W-1:0]       fcnt;

  logic [VALUE_W-1:0]      mag_next;
  logic [PREC_W-1:0]       prec_next;
  logic [PREC_W-1:0]       p_auto;
  logic [IW-1:0]           ipart;
  logic [VALUE_W-1:0]      rounder;
  logic [VALUE_W-1:0]      sum;
  logic [ND*4-1:0]         bcd_adj;
  logic [IDXW-1:0]         idx_next;
  logic [FB+3:0]           prod;
  logic [6:0]              ch;
  logic [VALUE_W-1:0]      rnd_tab [16];

  for (genvar g = 0; g < 16; g++) begin : g_rnd
    localparam logic [63:0] P   = pow10(g);
    localparam logic [63:0] RND = (g == 0 || g > 10) ? 64'd0 :
                                  (((64'd1 << FRACTION_BITS) + P) / (P * 64'd2));
    assign rnd_tab[g] = RND;
  end

  assign mag_next = s_tdata[63] ? (~s_tdata[63:0] + 64'd1) : s_tdata[63:0];
  assign ipart    = mag[VALUE_W-1:FB];
  assign rounder  = rnd_tab[prec];
  assign sum      = mag + rounder;
  assign prod     = ({4'b0, frac} << 3) + ({4'b0, frac} << 1);

  always_comb begin
    p_auto = '0;
    for (int k = 5; k >= 0; k--) begin
      if (ipart < IW'(pow10(k))) begin
        p_auto = PREC_W'(6 - k);
      end
    end
    if (cfg[CFG_W-1]) begin
      prec_next = p_auto;
    end else if (cfg[PREC_W-1:0] > PREC_W'(MAX_FRACTION_DIGITS)) begin
      prec_next = PREC_W'(MAX_FRACTION_DIGITS);
    end else begin
      prec_next = cfg[PREC_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    idx_next = '0;
    for (int i = 0; i < ND; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        idx_next = IDXW'(i);
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_MINUS: ch = CHAR_MINUS;
      SEL_INT:   ch = CHAR_ZERO + {3'b0, bcd[idx*4 +: 4]};
      SEL_DOT:   ch = CHAR_DOT;
      SEL_FRAC:  ch = CHAR_ZERO + {3'b0, prod[FB+3:FB]};
      default:   ch = CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= 5'sd3;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg <= cfg_data;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= s_tdata[63];
      mag <= mag_next;
    end
    if (cmd.prec) begin
      prec <= prec_next;
    end
    if (cmd.round) begin
      bin  <= sum[VALUE_W-1:FB];
      frac <= sum[FB-1:0];
      bcd  <= '0;
      dcnt <= DCW'(IW - 1);
    end
    if (cmd.dabble) begin
      {bcd, bin} <= {bcd_adj[ND*4-2:0], bin, 1'b0};
      dcnt       <= dcnt - 1'b1;
    end
    if (cmd.count) begin
      idx  <= idx_next;
      fcnt <= prec - 4'd1;
    end
    if (cmd.emit) begin
      m_tdata <= {1'b0, ch};
      m_tlast <= cmd.last;
      if (cmd.sel == SEL_INT) begin
        idx <= idx - 1'b1;
      end
      if (cmd.sel == SEL_FRAC) begin
        frac <= prod[FB-1:0];
        fcnt <= fcnt - 4'd1;
      end
    end
  end

  assign status.neg         = neg;
  assign status.prec_zero   = (prec == 4'd0);
  assign status.int_last    = (idx == '0);
  assign status.frac_last   = (fcnt == 4'd0);
  assign status.dabble_last = (dcnt == '0);
  assign status.out_free    = !m_tvalid || m_tready;

endmodule

// ----- hw/rtl/fpda_ctrl.sv -----
module fpda_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  fpda_pkg::fpda_status_t status,
  output fpda_pkg::fpda_cmd_t    cmd
);
  import fpda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREC,
    S_ROUND,
    S_DABBLE,
    S_COUNT,
    S_SIGN,
    S_INT,
    S_DOT,
    S_FRAC
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_MINUS;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PREC;
        end
      end
      S_PREC: begin
        cmd.prec   = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DABBLE;
      end
      S_DABBLE: begin
        cmd.dabble = 1'b1;
        if (status.dabble_last) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = status.neg ? S_SIGN : S_INT;
      end
      S_SIGN: begin
        cmd.sel = SEL_MINUS;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_INT;
        end
      end
      S_INT: begin
        cmd.sel  = SEL_INT;
        cmd.last = status.int_last && status.prec_zero;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.int_last) begin
            state_next = status.prec_zero ? S_IDLE : S_DOT;
          end
        end
      end
      S_DOT: begin
        cmd.sel = SEL_DOT;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd.sel  = SEL_FRAC;
        cmd.last = status.frac_last;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.frac_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/fixed_point_to_decimal_ascii_core.sv -----
// Channel  Dir  Ports                       Contents
// s        in   s_tvalid s_tready s_tdata   value (signed Q fixed point, bits 63:0)
// m        out  m_tvalid m_tready m_tdata   character (bits 6:0), zero pad bit 7
//                        m_tlast            is_last
// cfg      in   cfg_we cfg_data             fraction_digits (signed, 5 bits)
//
// Load, precision, rounding, the one-bit-per-cycle binary to BCD loop and a digit count
// precede the first character; characters follow one per cycle unless m_tready stalls.
// Synchronous active-high reset clears the controller, the output valid and sets
// fraction_digits to 3. A stalled m_tready holds the controller in its emit state;
// a new request is taken once the last character is in the output register.
module fixed_point_to_decimal_ascii_core #(
  parameter int MAX_FRACTION_DIGITS = 10,
  parameter int FRACTION_BITS       = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic signed [63:0] s_tdata,   // [63:0] value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [6:0] character, [7] zero
  output logic               m_tlast,
  input  logic               cfg_we,
  input  logic signed [4:0]  cfg_data
);
  import fpda_pkg::*;

  fpda_cmd_t    cmd;
  fpda_status_t status;

  fpda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fpda_datapath #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .FRACTION_BITS       (FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import fpda_pkg::*;

  localparam int FB = 32;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic signed [63:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;
  logic               cfg_we = 1'b0;
  logic signed [4:0]  cfg_data = '0;

  text_char_t        text_expected[$];
  logic signed [4:0] digits_setting = 5'sd3;
  bit                idle_en = 1'b0;
  bit                long_hold = 1'b0;
  int                errors = 0;

  fixed_point_to_decimal_ascii_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  function automatic void predict_text(input logic [63:0] raw, input logic signed [4:0] setting);
    logic [63:0] mag;
    logic [63:0] ipart;
    logic [63:0] frac;
    logic [63:0] d;
    logic [6:0]  chars[0:23];
    int          digs[0:23];
    int          p;
    int          n;
    int          nd;
    bit          found;
    text_char_t  c;
    n = 0;
    nd = 0;
    mag = raw[63] ? (~raw + 64'd1) : raw;
    p = setting;
    if (p > 10) begin
      p = 10;
    end
    if (raw[63]) begin
      chars[n] = CHAR_MINUS;
      n++;
    end
    if (p < 0) begin
      p = 0;
      found = 1'b0;
      for (int k = 0; k <= 5; k++) begin
        if (!found && mag < (ten_to(k) << FB)) begin
          p = 6 - k;
          found = 1'b1;
        end
      end
    end
    if (p > 0) begin
      d = ten_to(p);
      mag = mag + (((64'd1 << FB) + d) / (64'd2 * d));
    end
    ipart = mag >> FB;
    frac = mag & ((64'd1 << FB) - 64'd1);
    if (ipart == 0) begin
      chars[n] = CHAR_ZERO;
      n++;
    end else begin
      while (ipart != 0) begin
        digs[nd] = int'(ipart % 64'd10);
        nd++;
        ipart = ipart / 64'd10;
      end
      while (nd > 0) begin
        nd--;
        chars[n] = CHAR_ZERO + 7'(digs[nd]);
        n++;
      end
    end
    if (p > 0) begin
      chars[n] = CHAR_DOT;
      n++;
      for (int i = 0; i < p; i++) begin
        frac = frac * 64'd10;
        chars[n] = CHAR_ZERO + 7'(frac[FB+3:FB]);
        n++;
        frac = frac & ((64'd1 << FB) - 64'd1);
      end
    end
    for (int i = 0; i < n; i++) begin
      c.data = {1'b0, chars[i]};
      c.last = (i == n - 1);
      text_expected.push_back(c);
    end
  endfunction

  task automatic send_value(input logic [63:0] v);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    predict_text(v, digits_setting);
  endtask

  task automatic wait_text_done();
    s_tvalid <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_precision(input logic signed [4:0] p);
    cfg_we <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    digits_setting = p;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          sh;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: begin
        sh = $urandom_range(1, 63);
        v = {$urandom, $urandom} >> sh;
      end
      2: v = (ten_to($urandom_range(0, 9)) << FB) + 64'($urandom_range(0, 16)) - 64'd8;
      default: v = {32'($urandom_range(0, 99999)), $urandom};
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 64'd1;
    end
    return v;
  endfunction

  task automatic report_mismatch(input logic [7:0] exp_d, input logic exp_l,
                                 input logic [7:0] act_d, input logic act_l);
    errors++;
    if (errors <= 10) begin
      $display("mismatch: expected %h last %0d, got %h last %0d", exp_d, exp_l, act_d, act_l);
    end
  endtask

  always @(posedge clk) begin : check_text
    text_char_t c;
    if (!rst && m_tvalid && m_tready) begin
      if (text_expected.size() == 0) begin
        report_mismatch(8'h00, 1'b0, m_tdata, m_tlast);
      end else begin
        c = text_expected.pop_front();
        if (m_tdata !== c.data || m_tlast !== c.last) begin
          report_mismatch(c.data, c.last, m_tdata, m_tlast);
        end
      end
    end
  end

  initial begin : ready_gen
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        for (n = 0; n < 400; n++) @(posedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic test_reset_precision();
    send_value(64'd0);
    send_value(64'h0000_0001_0000_0000);
    send_value(64'hFFFF_FFFF_0000_0000);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'h0000_0000_8000_0000);
    send_value(64'h0000_0009_FFFF_0000);
    wait_text_done();
  endtask

  task automatic test_precision_extremes();
    write_precision(5'sd0);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    wait_text_done();
    write_precision(5'sd10);
    send_value(64'h0000_0000_1234_5678);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    wait_text_done();
    write_precision(5'sd15);
    send_value(64'hFFFF_FFFE_0000_0001);
    wait_text_done();
  endtask

  task automatic test_auto_precision();
    write_precision(-5'sd1);
    for (int k = 0; k <= 6; k++) begin
      send_value((ten_to(k) << FB) - 64'd1 - ((k % 2 == 1) ? 64'h0 : 64'h8000_0000));
    end
    wait_text_done();
    write_precision(-5'sd16);
    send_value(64'hFFFF_FFFF_FFFF_0000);
    wait_text_done();
  endtask

  task automatic test_random_phases();
    logic signed [4:0] settings[0:4];
    settings[0] = 5'($urandom_range(0, 31));
    settings[1] = 5'sd10;
    settings[2] = -5'sd1;
    settings[3] = 5'sd0;
    settings[4] = 5'($urandom_range(0, 31));
    idle_en = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      write_precision(settings[ph]);
      for (int i = 0; i < 26; i++) begin
        send_value(rand_value());
        if (ph == 2 && i == 12) begin
          wait_text_done();
        end
      end
      wait_text_done();
    end
  endtask

  task automatic test_backpressure();
    write_precision(5'($urandom_range(0, 31)));
    long_hold = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_value(rand_value());
    end
    wait_text_done();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    write_precision(5'sd10);
    for (int i = 0; i < 20; i++) begin
      send_value(rand_value());
    end
    wait_text_done();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_precision();
    test_precision_extremes();
    test_auto_precision();
    test_random_phases();
    test_backpressure();
    test_no_idle();
    repeat (80) @(posedge clk);
    if (errors == 0 && text_expected.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
